FILE: rtl/core/pot_filter_pwm_setpoint_core_defines.svh
// ----------------------------------------------------------------------------
// Pot filter PWM set-point core: assertion macros
// Shared helpers for the concurrent checks in the core's modules. They expect
// clk and rst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef POT_FILTER_PWM_SETPOINT_CORE_DEFINES_SVH
`define POT_FILTER_PWM_SETPOINT_CORE_DEFINES_SVH

// same-cycle implication
`define PFPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pfps_pkg.sv
// ----------------------------------------------------------------------------
// Pot filter PWM set-point package
// Types, widths and constants shared by the core's modules.
// ----------------------------------------------------------------------------
package pfps_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned PERIOD_W = 14;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned DIV_W    = 8;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned DIFF_W   = 16;
  localparam int unsigned GPROD_W  = DIFF_W + GAIN_W;
  localparam int unsigned MUL_W    = 22;
  localparam int unsigned PROD_W   = 2 * MUL_W;

  // fixed-point divide by 25 via reciprocal multiply
  localparam int unsigned FRAC_BITS   = 10;
  localparam int unsigned PCT_DIV     = 25;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));
  localparam int unsigned PCTX_W = 21;

  localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(100);
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_OFFSET     = 3'd0,
    REG_ADC_GAIN       = 3'd1,
    REG_GAIN_SHIFT     = 3'd2,
    REG_PERIOD_MIN     = 3'd3,
    REG_PERIOD_MAX     = 3'd4,
    REG_DUTY_MIN_PCT   = 3'd5,
    REG_DUTY_MAX_PCT   = 3'd6,
    REG_UPDATE_DIVIDER = 3'd7
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_DUTY = 2'd0,
    CMD_FREQ = 2'd1,
    CMD_TICK = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] adc_offset;
    logic [GAIN_W-1:0]   adc_gain;
    logic [SHIFT_W-1:0]  gain_shift;
    logic [PERIOD_W-1:0] period_min;
    logic [PERIOD_W-1:0] period_max;
    logic [PCT_W-1:0]    duty_min_pct;
    logic [PCT_W-1:0]    duty_max_pct;
    logic [DIV_W-1:0]    update_divider;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    adc_offset:     OFFSET_W'(0),
    adc_gain:       GAIN_W'(1024),
    gain_shift:     SHIFT_W'(12),
    period_min:     PERIOD_W'(100),
    period_max:     PERIOD_W'(1000),
    duty_min_pct:   PCT_W'(10),
    duty_max_pct:   PCT_W'(90),
    update_divider: DIV_W'(10)
  };

  typedef enum logic [2:0] {
    MS_GAIN_F = 3'd0,
    MS_GAIN_D = 3'd1,
    MS_SPAN   = 3'd2,
    MS_PCT_HI = 3'd3,
    MS_PCT_LO = 3'd4,
    MS_RECIP  = 3'd5,
    MS_DUTY   = 3'd6
  } mul_sel_t;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_DISP = 16'h0002,
    ST_SACC = 16'h0004,
    ST_MF   = 16'h0008,
    ST_SF   = 16'h0010,
    ST_MP   = 16'h0020,
    ST_PER  = 16'h0040,
    ST_MHI  = 16'h0080,
    ST_DHI  = 16'h0100,
    ST_MLO  = 16'h0200,
    ST_DLO  = 16'h0400,
    ST_MD   = 16'h0800,
    ST_SD   = 16'h1000,
    ST_MS   = 16'h2000,
    ST_FIN  = 16'h4000,
    ST_OUT  = 16'h8000
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     ram_rd;
    logic     win_upd;
    logic     tick_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_s;
    logic     ld_per;
    logic     ld_maxd;
    logic     ld_mind;
    logic     ld_duty;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic is_tick_active;
    logic tick_hit;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/core/pot_filter_pwm_setpoint_core.sv
// ----------------------------------------------------------------------------
// Pot filter PWM set-point core
// Moving-average filters for the duty and frequency pots with periodic linear
// scaling into a PWM period and duty set-point.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A duty or frequency sample passes through
// a window read from RAM, a sum update and the result register; a control tick
// passes straight to the result register unless it triggers a
// set-point recompute, which runs eight dependent products (gain for each pot,
// span, both percent limits with their divide by 25, duty span) through one
// shared 22x22 multiplier. A result is held in the output register until taken;
// the next item is accepted meanwhile and waits only at its own result.
// No clearing pass is needed after reset: unfilled window slots read as zero.
module pot_filter_pwm_setpoint_core #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample/tick transfers
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample
  input  logic [2:0]                            in_tuser,   // cmd, pot_mode_active
  // result transfers
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+37)/8)*8-1:0]     out_tdata,  // filtered, period, duty
  output logic                                  out_tuser,  // updated
  // configuration
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [pfps_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [pfps_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [pfps_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned OUT_TDATA_W = ((SAMPLE_BITS + 37) / 8) * 8;
  localparam int unsigned OUT_BITS    = SAMPLE_BITS + pfps_pkg::PERIOD_W + pfps_pkg::DUTY_W;

  pfps_pkg::cfg_t    cfg;
  pfps_pkg::dp_cmd_t cmd;
  pfps_pkg::dp_sts_t sts;

  logic [SAMPLE_BITS-1:0]        filtered;
  logic [pfps_pkg::PERIOD_W-1:0] period;
  logic [pfps_pkg::DUTY_W-1:0]   duty;
  logic [OUT_BITS-1:0]           out_bits;

  pfps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfps_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .in_cmd       (in_tuser[pfps_pkg::CMD_W-1:0]),
    .in_sample    (in_tdata[SAMPLE_BITS-1:0]),
    .in_active    (in_tuser[pfps_pkg::CMD_W]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_filtered (filtered),
    .out_period   (period),
    .out_duty     (duty),
    .out_updated  (out_tuser)
  );

  assign out_bits  = {duty, period, filtered};
  assign out_tdata = OUT_TDATA_W'(out_bits);

endmodule

FILE: rtl/core/pfps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfps_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/pfps_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the scaling and update settings.
// ----------------------------------------------------------------------------
module pfps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pfps_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pfps_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pfps_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output pfps_pkg::cfg_t                   cfg
);

  pfps_pkg::cfg_t     cfg_r, cfg_nxt;
  pfps_pkg::reg_idx_t idx;
  logic               wr;

  assign idx        = pfps_pkg::reg_idx_t'(cfg_paddr[pfps_pkg::CFG_ADDR_W-1:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        pfps_pkg::REG_ADC_OFFSET:
          cfg_nxt.adc_offset = cfg_pwdata[pfps_pkg::OFFSET_W-1:0];
        pfps_pkg::REG_ADC_GAIN:
          cfg_nxt.adc_gain = cfg_pwdata[pfps_pkg::GAIN_W-1:0];
        pfps_pkg::REG_GAIN_SHIFT:
          cfg_nxt.gain_shift = cfg_pwdata[pfps_pkg::SHIFT_W-1:0];
        pfps_pkg::REG_PERIOD_MIN:
          cfg_nxt.period_min = cfg_pwdata[pfps_pkg::PERIOD_W-1:0];
        pfps_pkg::REG_PERIOD_MAX:
          cfg_nxt.period_max = cfg_pwdata[pfps_pkg::PERIOD_W-1:0];
        pfps_pkg::REG_DUTY_MIN_PCT:
          cfg_nxt.duty_min_pct = cfg_pwdata[pfps_pkg::PCT_W-1:0];
        pfps_pkg::REG_DUTY_MAX_PCT:
          cfg_nxt.duty_max_pct = cfg_pwdata[pfps_pkg::PCT_W-1:0];
        pfps_pkg::REG_UPDATE_DIVIDER:
          cfg_nxt.update_divider = cfg_pwdata[pfps_pkg::DIV_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pfps_pkg::REG_ADC_OFFSET:     cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.adc_offset);
      pfps_pkg::REG_ADC_GAIN:       cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.adc_gain);
      pfps_pkg::REG_GAIN_SHIFT:     cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.gain_shift);
      pfps_pkg::REG_PERIOD_MIN:     cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.period_min);
      pfps_pkg::REG_PERIOD_MAX:     cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.period_max);
      pfps_pkg::REG_DUTY_MIN_PCT:   cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.duty_min_pct);
      pfps_pkg::REG_DUTY_MAX_PCT:   cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.duty_max_pct);
      pfps_pkg::REG_UPDATE_DIVIDER: cfg_prdata = pfps_pkg::CFG_DATA_W'(cfg_r.update_divider);
      default:                      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pfps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/pfps_ctrl.sv
// ----------------------------------------------------------------------------
// Set-point controller
// Sequences window updates and the set-point recompute over the datapath.
// ----------------------------------------------------------------------------
module pfps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfps_pkg::dp_sts_t  sts,
  output pfps_pkg::dp_cmd_t  cmd
);

`include "pot_filter_pwm_setpoint_core_defines.svh"

  pfps_pkg::state_t state_r, state_nxt;

  assign in_ready = (state_r == pfps_pkg::ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = pfps_pkg::MS_GAIN_F;
    unique case (state_r)
      pfps_pkg::ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = pfps_pkg::ST_DISP;
        end
      end
      pfps_pkg::ST_DISP: begin
        if (sts.is_sample) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = pfps_pkg::ST_SACC;
        end else if (sts.is_tick_active) begin
          cmd.tick_step = 1'b1;
          state_nxt     = sts.tick_hit ? pfps_pkg::ST_MF : pfps_pkg::ST_OUT;
        end else begin
          state_nxt = pfps_pkg::ST_OUT;
        end
      end
      pfps_pkg::ST_SACC: begin
        cmd.win_upd = 1'b1;
        state_nxt   = pfps_pkg::ST_OUT;
      end
      pfps_pkg::ST_MF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_GAIN_F;
        state_nxt   = pfps_pkg::ST_SF;
      end
      pfps_pkg::ST_SF: begin
        cmd.ld_s  = 1'b1;
        state_nxt = pfps_pkg::ST_MP;
      end
      pfps_pkg::ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_SPAN;
        state_nxt   = pfps_pkg::ST_PER;
      end
      pfps_pkg::ST_PER: begin
        cmd.ld_per = 1'b1;
        state_nxt  = pfps_pkg::ST_MHI;
      end
      pfps_pkg::ST_MHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_PCT_HI;
        state_nxt   = pfps_pkg::ST_DHI;
      end
      pfps_pkg::ST_DHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_RECIP;
        state_nxt   = pfps_pkg::ST_MLO;
      end
      pfps_pkg::ST_MLO: begin
        cmd.ld_maxd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_PCT_LO;
        state_nxt   = pfps_pkg::ST_DLO;
      end
      pfps_pkg::ST_DLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_RECIP;
        state_nxt   = pfps_pkg::ST_MD;
      end
      pfps_pkg::ST_MD: begin
        cmd.ld_mind = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_GAIN_D;
        state_nxt   = pfps_pkg::ST_SD;
      end
      pfps_pkg::ST_SD: begin
        cmd.ld_s  = 1'b1;
        state_nxt = pfps_pkg::ST_MS;
      end
      pfps_pkg::ST_MS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pfps_pkg::MS_DUTY;
        state_nxt   = pfps_pkg::ST_FIN;
      end
      pfps_pkg::ST_FIN: begin
        cmd.ld_duty = 1'b1;
        state_nxt   = pfps_pkg::ST_OUT;
      end
      pfps_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pfps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PFPS_ASSERT_NOW(a_out_load_free, cmd.out_load, sts.out_free, "result loaded over pending one")

endmodule

FILE: rtl/core/pfps_dp.sv
// ----------------------------------------------------------------------------
// Set-point datapath
// Window store, running sums, shared multiplier, set-point and result regs.
// ----------------------------------------------------------------------------
module pfps_dp #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfps_pkg::cfg_t                   cfg,
  input  pfps_pkg::dp_cmd_t                cmd,
  output pfps_pkg::dp_sts_t                sts,
  input  logic [pfps_pkg::CMD_W-1:0]       in_cmd,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  logic                             in_active,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SAMPLE_BITS-1:0]           out_filtered,
  output logic [pfps_pkg::PERIOD_W-1:0]    out_period,
  output logic [pfps_pkg::DUTY_W-1:0]      out_duty,
  output logic                             out_updated
);

`include "pot_filter_pwm_setpoint_core_defines.svh"

  localparam int unsigned PTR_W      = $clog2(WINDOW_DEPTH);
  localparam int unsigned RAM_DEPTH  = 2 ** (PTR_W + 1);
  localparam int unsigned SUM_W      = SAMPLE_BITS + PTR_W;
  localparam int unsigned MEAN_SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);
  localparam int unsigned SPROD_W    = pfps_pkg::SCALE_W + pfps_pkg::PERIOD_W;
  localparam int unsigned DPROD_W    = pfps_pkg::SCALE_W + pfps_pkg::DUTY_W;

  // item
  logic [pfps_pkg::CMD_W-1:0] item_cmd_r;
  logic [SAMPLE_BITS-1:0]     smp_r;
  logic                       act_r;
  logic                       upd_r;
  logic                       ch;

  // windows
  logic [PTR_W-1:0]       ptr_r  [2];
  logic                   full_r [2];
  logic [SUM_W-1:0]       sum_r  [2];
  logic [SAMPLE_BITS-1:0] mean_r [2];
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SUM_W-1:0]       sum_nxt;
  logic [PTR_W:0]         ram_addr;

  // tick
  logic [pfps_pkg::DIV_W-1:0] tick_r, tick_inc;

  // scaling
  logic [pfps_pkg::PROD_W-1:0]   prod_r;
  logic [pfps_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [pfps_pkg::SCALE_W-1:0]  s_r, s_nxt;
  logic [pfps_pkg::GPROD_W-1:0]  shifted;
  logic [pfps_pkg::DIFF_W-1:0]   off_ext, mean_f_ext, mean_d_ext, d_f, d_d;
  logic [pfps_pkg::PCT_W-1:0]    pct_hi, pct_lo;
  logic                          up;
  logic [pfps_pkg::PERIOD_W-1:0] span, per_nxt, q_up;
  logic [SPROD_W:0]              rnd;
  logic [pfps_pkg::PERIOD_W-1:0] q_dn;
  logic [pfps_pkg::PERIOD_W-1:0] period_r;
  logic [pfps_pkg::DUTY_W-1:0]   maxd_r, mind_r, duty_r, duty_nxt, dspan, dq;

  // result
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_filt_r;
  logic [pfps_pkg::PERIOD_W-1:0] out_period_r;
  logic [pfps_pkg::DUTY_W-1:0]   out_duty_r;
  logic                          out_upd_r;
  logic                          is_sample;

  assign ch        = item_cmd_r[0];
  assign is_sample = (item_cmd_r == pfps_pkg::CMD_DUTY) || (item_cmd_r == pfps_pkg::CMD_FREQ);
  assign tick_inc  = tick_r + 1'b1;

  assign sts.is_sample      = is_sample;
  assign sts.is_tick_active = (item_cmd_r == pfps_pkg::CMD_TICK) && act_r;
  assign sts.tick_hit       = (tick_inc == cfg.update_divider);
  assign sts.out_free       = !out_valid_r || out_ready;

  // window store: both channels share one RAM, channel in the top address bit
  assign ram_addr = {ch, ptr_r[ch]};

  pfps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (cmd.win_upd),
    .waddr (ram_addr),
    .wdata (smp_r),
    .re    (cmd.ram_rd),
    .raddr (ram_addr),
    .rdata (rdata)
  );

  // entries not yet written read as zero
  assign old_smp = full_r[ch] ? rdata : '0;
  assign sum_nxt = sum_r[ch] - SUM_W'(old_smp) + SUM_W'(smp_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd_r <= in_cmd;
      smp_r      <= in_sample;
      act_r      <= in_active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        ptr_r[i]  <= '0;
        full_r[i] <= 1'b0;
        sum_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else if (cmd.win_upd) begin
      sum_r[ch]  <= sum_nxt;
      mean_r[ch] <= SAMPLE_BITS'(sum_nxt >> MEAN_SHIFT);
      if (ptr_r[ch] == LAST_PTR) begin
        ptr_r[ch]  <= '0;
        full_r[ch] <= 1'b1;
      end else begin
        ptr_r[ch] <= ptr_r[ch] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (cmd.tick_step) begin
      tick_r <= sts.tick_hit ? '0 : tick_inc;
    end
  end

  // offset removal with floor at zero
  assign off_ext    = pfps_pkg::DIFF_W'(cfg.adc_offset);
  assign mean_d_ext = pfps_pkg::DIFF_W'(mean_r[0]);
  assign mean_f_ext = pfps_pkg::DIFF_W'(mean_r[1]);
  assign d_d        = (mean_d_ext >= off_ext) ? (mean_d_ext - off_ext) : '0;
  assign d_f        = (mean_f_ext >= off_ext) ? (mean_f_ext - off_ext) : '0;

  assign pct_hi = (cfg.duty_max_pct > pfps_pkg::PCT_MAX) ? pfps_pkg::PCT_MAX : cfg.duty_max_pct;
  assign pct_lo = (cfg.duty_min_pct > pfps_pkg::PCT_MAX) ? pfps_pkg::PCT_MAX : cfg.duty_min_pct;

  assign up    = (cfg.period_max >= cfg.period_min);
  assign span  = up ? (cfg.period_max - cfg.period_min) : (cfg.period_min - cfg.period_max);
  assign dspan = maxd_r - mind_r;

  always_comb begin
    unique case (cmd.mul_sel)
      pfps_pkg::MS_GAIN_F: begin
        mul_a = pfps_pkg::MUL_W'(d_f);
        mul_b = pfps_pkg::MUL_W'(cfg.adc_gain);
      end
      pfps_pkg::MS_GAIN_D: begin
        mul_a = pfps_pkg::MUL_W'(d_d);
        mul_b = pfps_pkg::MUL_W'(cfg.adc_gain);
      end
      pfps_pkg::MS_SPAN: begin
        mul_a = pfps_pkg::MUL_W'(s_r);
        mul_b = pfps_pkg::MUL_W'(span);
      end
      pfps_pkg::MS_PCT_HI: begin
        mul_a = pfps_pkg::MUL_W'(pct_hi);
        mul_b = pfps_pkg::MUL_W'(period_r);
      end
      pfps_pkg::MS_PCT_LO: begin
        mul_a = pfps_pkg::MUL_W'(pct_lo);
        mul_b = pfps_pkg::MUL_W'(period_r);
      end
      pfps_pkg::MS_RECIP: begin
        mul_a = pfps_pkg::MUL_W'(prod_r[pfps_pkg::PCTX_W-1:0]);
        mul_b = pfps_pkg::RECIP;
      end
      pfps_pkg::MS_DUTY: begin
        mul_a = pfps_pkg::MUL_W'(s_r);
        mul_b = pfps_pkg::MUL_W'(dspan);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // gain shift and clamp to ten bits
  assign shifted = prod_r[pfps_pkg::GPROD_W-1:0] >> cfg.gain_shift;
  assign s_nxt   = (|shifted[pfps_pkg::GPROD_W-1:pfps_pkg::SCALE_W]) ? pfps_pkg::SCALE_MAX
                                                                     : shifted[pfps_pkg::SCALE_W-1:0];

  // interpolation; downward direction rounds the step up
  assign q_up    = prod_r[SPROD_W-1:pfps_pkg::FRAC_BITS];
  assign rnd     = {1'b0, prod_r[SPROD_W-1:0]} + (SPROD_W+1)'(pfps_pkg::SCALE_MAX);
  assign q_dn    = rnd[SPROD_W-1:pfps_pkg::FRAC_BITS];
  assign per_nxt = up ? (cfg.period_min + q_up) : (cfg.period_min - q_dn);

  assign dq       = prod_r[DPROD_W-1:pfps_pkg::FRAC_BITS];
  assign duty_nxt = (mind_r > maxd_r) ? mind_r : (maxd_r - dq);

  always_ff @(posedge clk) begin
    if (cmd.ld_s) begin
      s_r <= s_nxt;
    end
    if (cmd.ld_maxd) begin
      maxd_r <= prod_r[pfps_pkg::RECIP_SHIFT +: pfps_pkg::DUTY_W];
    end
    if (cmd.ld_mind) begin
      mind_r <= prod_r[pfps_pkg::RECIP_SHIFT +: pfps_pkg::DUTY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      duty_r   <= '0;
      upd_r    <= 1'b0;
    end else begin
      if (cmd.ld_per) begin
        period_r <= per_nxt;
      end
      if (cmd.ld_duty) begin
        duty_r <= duty_nxt;
        upd_r  <= 1'b1;
      end else if (cmd.accept) begin
        upd_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_filt_r   <= is_sample ? mean_r[ch] : '0;
      out_period_r <= period_r;
      out_duty_r   <= duty_r;
      out_upd_r    <= upd_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filt_r;
  assign out_period   = out_period_r;
  assign out_duty     = out_duty_r;
  assign out_updated  = out_upd_r;

  `PFPS_ASSERT_NOW(a_upd_tick_clear, cmd.out_load && upd_r, tick_r == '0, "update without tick clear")
  `PFPS_ASSERT_NOW(a_sample_no_upd, cmd.out_load && is_sample, !upd_r, "sample flagged as update")
  `PFPS_ASSERT_NEXT(a_duty_floor, cmd.ld_duty, duty_r >= $past(mind_r), "duty below minimum")

endmodule

FILE: bench/pot_filter_pwm_setpoint_core_tb.sv
// ----------------------------------------------------------------------------
// Pot filter PWM set-point core testbench
// Drives duty/frequency samples and control ticks into the core and checks
// each result against a built-in model of the window filters and set-point
// scaling. It covers a directed table, then random phases under
// several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module pot_filter_pwm_setpoint_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned AVG_SHIFT = $clog2(DEPTH);
  localparam int unsigned PCT_CEIL  = 100;
  localparam int unsigned PCT_STEP  = 25;
  localparam int unsigned S_CEIL    = 1023;
  localparam logic [pfps_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int CH_DUTY = 0;
  localparam int CH_FREQ = 1;

  typedef struct packed {
    logic [11:0] filtered;
    logic [13:0] period;
    logic [15:0] duty;
    logic        updated;
  } setpoint_t;

  typedef struct packed {
    logic [pfps_pkg::CMD_W-1:0] cmd;
    logic [11:0]                smp;
    logic                       act;
    logic                       pinned;
    setpoint_t                  want;
  } probe_t;

  typedef struct packed {
    pfps_pkg::cfg_t cfg;
    int             items;
    int             tick_pct;
    int             tx_odds;
    int             rx_odds;
  } phase_t;

  // pinned rows carry their own expectation; the rest go through the model
  localparam int N_PROBES = 20;
  localparam probe_t PROBES [N_PROBES] = '{
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b0, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{CMD_SPARE, 12'hFFF,           1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_DUTY, 12'hFFF,  1'b0, 1'b1, '{12'd255, 14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_FREQ, 12'hFFF,  1'b1, 1'b1, '{12'd255, 14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_FREQ, 12'd0,    1'b1, 1'b1, '{12'd255, 14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_FREQ, 12'hFFF,  1'b0, 1'b1, '{12'd511, 14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'hFFF,  1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b0, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'h555,  1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'hAAA,  1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b1, '{12'd0,   14'd0, 16'd0, 1'b0}},
    '{pfps_pkg::CMD_TICK, 12'd0,    1'b1, 1'b0, '0},
    '{pfps_pkg::CMD_DUTY, 12'd0,    1'b1, 1'b0, '0},
    '{CMD_SPARE, 12'd0,             1'b0, 1'b0, '0},
    '{pfps_pkg::CMD_FREQ, 12'h800,  1'b1, 1'b0, '0}
  };

  // cfg fields: offset, gain, shift, period min, period max, min %, max %, divider
  localparam int N_PHASES = 9;
  localparam phase_t PHASES [N_PHASES] = '{
    '{pfps_pkg::CFG_RESET, 25, 30, 5, 5},
    '{'{12'd100, 16'd65535, 5'd16, 14'd16383, 14'd16383, 7'd100, 7'd101, 8'd255},
      20, 40, 0, 8},
    '{'{12'd0, 16'd1024, 5'd12, 14'd100, 14'd1000, 7'd10, 7'd90, 8'd0},
      400, 95, 12, 12},
    '{'{12'd0, 16'd65535, 5'd0, 14'd1, 14'd16383, 7'd0, 7'd100, 8'd1},
      30, 35, 4, 0},
    '{'{12'd0, 16'd1024, 5'd12, 14'd0, 14'd16383, 7'd0, 7'd100, 8'd1},
      30, 40, 6, 6},
    '{'{12'd4095, 16'd0, 5'd31, 14'd16383, 14'd0, 7'd127, 7'd127, 8'd2},
      30, 35, 0, 4},
    '{'{12'd300, 16'd4096, 5'd10, 14'd5000, 14'd200, 7'd80, 7'd20, 8'd3},
      35, 40, 5, 10},
    '{'{12'd1000, 16'd3000, 5'd11, 14'd200, 14'd9000, 7'd25, 7'd75, 8'd4},
      35, 40, 8, 5},
    '{'{12'd50, 16'd2048, 5'd12, 14'd37, 14'd12000, 7'd5, 7'd95, 8'd1},
      50, 35, 0, 0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [15:0]                     in_tdata;   // [11:0] sample, rest zero
  logic [2:0]                      in_tuser;   // [1:0] cmd, [2] pot_mode_active
  logic                            out_tvalid;
  logic                            out_tready;
  logic [47:0]                     out_tdata;  // [11:0] filtered, [25:12] period, [41:26] duty
  logic                            out_tuser;  // [0] updated
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [pfps_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [pfps_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [pfps_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  pot_filter_pwm_setpoint_core #(
    .WINDOW_DEPTH(DEPTH),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // model state
  pfps_pkg::cfg_t pot_cfg;
  logic [11:0]    pot_win [2][DEPTH];
  logic [15:0]    pot_sum [2];
  logic [11:0]    pot_avg [2];
  logic [7:0]     tick_cnt;
  logic [13:0]    period_sp;
  logic [15:0]    duty_sp;
  int             refresh_cnt;

  setpoint_t   due_results[$];
  int          mismatches;
  int          results_seen;
  int          tx_odds;
  int          rx_odds;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned scale_pot(logic [11:0] mean);
    longint unsigned d;
    longint unsigned p;
    d = (mean >= pot_cfg.adc_offset) ? 64'(mean) - 64'(pot_cfg.adc_offset) : 64'd0;
    p = (d * 64'(pot_cfg.adc_gain)) >> pot_cfg.gain_shift;
    return (p > S_CEIL) ? S_CEIL : int'(p);
  endfunction

  // floor interpolation, running downward when hi < lo
  function automatic int unsigned span_lerp(int unsigned s, int unsigned lo,
                                            int unsigned hi);
    if (hi >= lo)
      return lo + ((s * (hi - lo)) >> 10);
    return lo - ((s * (lo - hi) + 1023) >> 10);
  endfunction

  function automatic void refresh_setpoint();
    int unsigned pct_hi;
    int unsigned pct_lo;
    int unsigned per;
    int unsigned max_d;
    int unsigned min_d;
    int unsigned d;
    pct_hi = (pot_cfg.duty_max_pct > PCT_CEIL) ? PCT_CEIL : pot_cfg.duty_max_pct;
    pct_lo = (pot_cfg.duty_min_pct > PCT_CEIL) ? PCT_CEIL : pot_cfg.duty_min_pct;
    per = span_lerp(scale_pot(pot_avg[CH_FREQ]), pot_cfg.period_min,
                    pot_cfg.period_max) & 32'h3FFF;
    max_d = pct_hi * per / PCT_STEP;
    min_d = pct_lo * per / PCT_STEP;
    if (min_d > max_d)
      d = min_d;
    else
      d = max_d - ((scale_pot(pot_avg[CH_DUTY]) * (max_d - min_d)) >> 10);
    period_sp = 14'(per);
    duty_sp   = 16'(d);
    refresh_cnt++;
  endfunction

  function automatic setpoint_t advance_pots(logic [pfps_pkg::CMD_W-1:0] cmd,
                                             logic [11:0] smp, logic act);
    setpoint_t r;
    int        ch;
    r = '0;
    if (cmd == pfps_pkg::CMD_DUTY || cmd == pfps_pkg::CMD_FREQ) begin
      ch = (cmd == pfps_pkg::CMD_FREQ) ? CH_FREQ : CH_DUTY;
      pot_sum[ch] = pot_sum[ch] - 16'(pot_win[ch][0]) + 16'(smp);
      for (int i = 0; i < DEPTH - 1; i++)
        pot_win[ch][i] = pot_win[ch][i+1];
      pot_win[ch][DEPTH-1] = smp;
      pot_avg[ch] = 12'(pot_sum[ch] >> AVG_SHIFT);
      r.filtered = pot_avg[ch];
    end else if (cmd == pfps_pkg::CMD_TICK && act) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == pot_cfg.update_divider) begin
        refresh_setpoint();
        tick_cnt  = '0;
        r.updated = 1'b1;
      end
    end
    r.period = period_sp;
    r.duty   = duty_sp;
    return r;
  endfunction

  function automatic logic [pfps_pkg::CFG_DATA_W-1:0] reg_value(pfps_pkg::cfg_t c,
                                                                pfps_pkg::reg_idx_t r);
    case (r)
      pfps_pkg::REG_ADC_OFFSET:   return pfps_pkg::CFG_DATA_W'(c.adc_offset);
      pfps_pkg::REG_ADC_GAIN:     return pfps_pkg::CFG_DATA_W'(c.adc_gain);
      pfps_pkg::REG_GAIN_SHIFT:   return pfps_pkg::CFG_DATA_W'(c.gain_shift);
      pfps_pkg::REG_PERIOD_MIN:   return pfps_pkg::CFG_DATA_W'(c.period_min);
      pfps_pkg::REG_PERIOD_MAX:   return pfps_pkg::CFG_DATA_W'(c.period_max);
      pfps_pkg::REG_DUTY_MIN_PCT: return pfps_pkg::CFG_DATA_W'(c.duty_min_pct);
      pfps_pkg::REG_DUTY_MAX_PCT: return pfps_pkg::CFG_DATA_W'(c.duty_max_pct);
      default:                    return pfps_pkg::CFG_DATA_W'(c.update_divider);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic apb_access(input pfps_pkg::reg_idx_t r, input logic wr,
                            input logic [pfps_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [pfps_pkg::CFG_DATA_W-1:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_reg(input pfps_pkg::reg_idx_t r, input pfps_pkg::cfg_t c);
    logic [pfps_pkg::CFG_DATA_W-1:0] rd;
    apb_access(r, 1'b0, '0, rd);
    if (rd !== reg_value(c, r)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %s: expected %0d, read %0d", r.name(), reg_value(c, r), rd);
    end
  endtask

  task automatic load_regs(input pfps_pkg::cfg_t c);
    pfps_pkg::reg_idx_t              r;
    logic [pfps_pkg::CFG_DATA_W-1:0] rd;
    r = r.first();
    repeat (r.num()) begin
      apb_access(r, 1'b1, reg_value(c, r), rd);
      check_reg(r, c);
      r = r.next();
    end
    pot_cfg = c;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [pfps_pkg::CMD_W-1:0] cmd, input logic [11:0] smp,
                           input logic act, input logic pinned, input setpoint_t want);
    setpoint_t pred;
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, smp};
    in_tuser  = {act, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = advance_pots(cmd, smp, act);
    due_results.push_back(pinned ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // result side
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    setpoint_t got;
    setpoint_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[11:0], out_tdata[25:12], out_tdata[41:26], out_tuser};
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("transfer %0d: result with nothing outstanding", results_seen);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("transfer %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     results_seen,
                     want.filtered, want.period, want.duty, want.updated,
                     got.filtered, got.period, got.duty, got.updated);
        end
      end
    end
  end

  initial begin
    phase_t                     ph;
    logic [pfps_pkg::CMD_W-1:0] cmd;
    logic [11:0]                smp;
    logic                       act;
    int                         pick;
    int                         refresh_mark;
    pfps_pkg::reg_idx_t         r;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatches  = 0;
    results_seen = 0;
    refresh_cnt = 0;
    tx_odds     = 0;
    rx_odds     = 0;
    pot_cfg     = pfps_pkg::CFG_RESET;
    pot_win     = '{default: '{default: '0}};
    pot_sum     = '{default: '0};
    pot_avg     = '{default: '0};
    tick_cnt    = '0;
    period_sp   = '0;
    duty_sp     = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of the registers
    r = r.first();
    repeat (r.num()) begin
      check_reg(r, pfps_pkg::CFG_RESET);
      r = r.next();
    end

    tx_odds = 4;
    rx_odds = 4;
    for (int i = 0; i < N_PROBES; i++)
      send_item(PROBES[i].cmd, PROBES[i].smp, PROBES[i].act, PROBES[i].pinned,
                PROBES[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      ph = PHASES[p];
      if (p != 0) begin
        drain();
        load_regs(ph.cfg);
      end
      tx_odds = ph.tx_odds;
      rx_odds = ph.rx_odds;
      refresh_mark = refresh_cnt;
      for (int k = 0; k < ph.items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < ph.tick_pct)
          cmd = pfps_pkg::CMD_TICK;
        else if (pick < ph.tick_pct + 3)
          cmd = CMD_SPARE;
        else
          cmd = $urandom_range(0, 1) ? pfps_pkg::CMD_FREQ : pfps_pkg::CMD_DUTY;
        if ($urandom_range(0, 9) == 0)
          smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        else
          smp = 12'($urandom_range(0, 4095));
        act = ($urandom_range(0, 9) != 0);
        send_item(cmd, smp, act, 1'b0, '0);
        // divider zero: stop once the counter has wrapped onto it
        if (ph.cfg.update_divider == '0 && refresh_cnt != refresh_mark)
          break;
      end
    end

    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
